// ----- src/smpg_pkg.sv -----
// ============================================================================
// Step pulse generator package
// Shared codes, field widths, reset values and helpers for the step/dir block.
// ============================================================================
`default_nettype none

package smpg_pkg;

  // Default widths of the position counter and the tick timer.
  localparam int POS_BITS_DEF   = 20;
  localparam int TIMER_BITS_DEF = 24;

  // Fixed width of the step size register.
  localparam int STEP_W = 9;

  // Register reset values.
  localparam int STEP_RESET  = 1;
  localparam int LIMIT_RESET = 3600;
  localparam int WRAP_RESET  = 101200;
  localparam int HALF_RESET  = 741;
  localparam int NUDGE_RESET = 1483;

  // Configuration register indexes.
  localparam logic [2:0] REG_STEP_SIZE = 3'd0;
  localparam logic [2:0] REG_LIMIT     = 3'd1;
  localparam logic [2:0] REG_WRAP      = 3'd2;
  localparam logic [2:0] REG_HALF      = 3'd3;
  localparam logic [2:0] REG_NUDGE     = 3'd4;

  // Request kinds carried on the input user field.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_HALT  = 2'd2,
    MODE_NUDGE = 2'd3
  } mode_t;

  // Wait phase of the step sequencer.
  typedef enum logic [3:0] {
    PH_CHECK = 4'b0001,
    PH_HALF1 = 4'b0010,
    PH_HALF2 = 4'b0100,
    PH_NUDGE = 4'b1000
  } phase_t;

  // Pin vector layout: bit 0 step, bit 1 dir, bit 2 enable.
  localparam int PIN_STEP_BIT = 0;
  localparam int PIN_DIR_BIT  = 1;
  localparam int PIN_EN_BIT   = 2;
  localparam logic [2:0] PINS_RELEASED = 3'b111;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- src/smpg_cfg_regs.sv -----
// ============================================================================
// Step pulse generator configuration registers
// Write-only register file; flags a remainder refresh on step or wrap writes.
// ============================================================================
`default_nettype none

module smpg_cfg_regs #(
  parameter int POS_BITS   = smpg_pkg::POS_BITS_DEF,
  parameter int TIMER_BITS = smpg_pkg::TIMER_BITS_DEF,
  localparam int CFG_W     = smpg_pkg::max_int(TIMER_BITS, POS_BITS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_addr,
  input  wire logic [CFG_W-1:0]            cfg_wdata,
  output logic      [smpg_pkg::STEP_W-1:0] step_size,
  output logic      [POS_BITS-1:0]         position_limit,
  output logic      [POS_BITS:0]           wrap_count,
  output logic      [TIMER_BITS-1:0]       half_period,
  output logic      [TIMER_BITS-1:0]       nudge_period,
  output logic                             recalc
);
  import smpg_pkg::*;

  logic [STEP_W-1:0]     step_r;
  logic [POS_BITS-1:0]   limit_r;
  logic [POS_BITS:0]     wrap_r;
  logic [TIMER_BITS-1:0] half_r;
  logic [TIMER_BITS-1:0] nudge_r;
  logic                  recalc_r;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_W'(STEP_RESET);
      limit_r  <= POS_BITS'(LIMIT_RESET);
      wrap_r   <= (POS_BITS + 1)'(WRAP_RESET);
      half_r   <= TIMER_BITS'(HALF_RESET);
      nudge_r  <= TIMER_BITS'(NUDGE_RESET);
      recalc_r <= 1'b0;
    end else begin
      recalc_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_SIZE: begin
            step_r   <= cfg_wdata[STEP_W-1:0];
            recalc_r <= 1'b1;
          end
          REG_LIMIT: limit_r <= cfg_wdata[POS_BITS-1:0];
          REG_WRAP: begin
            wrap_r   <= cfg_wdata[POS_BITS:0];
            recalc_r <= 1'b1;
          end
          REG_HALF:  half_r  <= cfg_wdata[TIMER_BITS-1:0];
          REG_NUDGE: nudge_r <= cfg_wdata[TIMER_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  assign step_size      = step_r;
  assign position_limit = limit_r;
  assign wrap_count     = wrap_r;
  assign half_period    = half_r;
  assign nudge_period   = nudge_r;
  assign recalc         = recalc_r;

endmodule

`default_nettype wire

// ----- src/smpg_mod_unit.sv -----
// ============================================================================
// Step pulse generator remainder unit
// Bit-serial restoring remainder of position, step size and latched step.
// ============================================================================
`default_nettype none

module smpg_mod_unit #(
  parameter int POS_BITS = smpg_pkg::POS_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [POS_BITS:0]           wrap_count,
  input  wire logic [POS_BITS-1:0]         pos_in,
  input  wire logic [smpg_pkg::STEP_W-1:0] step_in,
  input  wire logic [smpg_pkg::STEP_W-1:0] mag_in,
  output logic                             busy,
  output logic                             done,
  output logic      [POS_BITS-1:0]         pos_mod,
  output logic      [smpg_pkg::STEP_W-1:0] step_mod,
  output logic      [smpg_pkg::STEP_W-1:0] mag_mod
);
  import smpg_pkg::*;

  localparam int DW    = max_int(POS_BITS, STEP_W);
  localparam int RW    = POS_BITS + 2;
  localparam int CW    = $clog2(DW + 1);
  localparam int LANES = 3;

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [POS_BITS:0] w_r;
  logic [DW-1:0]   div_r [LANES];
  logic [RW-1:0]   rem_r [LANES];
  logic [RW-1:0]   rem_nxt [LANES];
  logic [RW-1:0]   w_ext;

  assign w_ext = {1'b0, w_r};

  // One quotient bit per cycle in every lane.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [RW-1:0] shifted;
    assign shifted    = {rem_r[i][RW-2:0], div_r[i][DW-1]};
    assign rem_nxt[i] = (shifted >= w_ext) ? (shifted - w_ext) : shifted;
  end

  // Sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shift and partial remainders.
  always_ff @(posedge clk) begin
    if (start) begin
      w_r      <= wrap_count;
      div_r[0] <= DW'(pos_in);
      div_r[1] <= DW'(step_in);
      div_r[2] <= DW'(mag_in);
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < LANES; i++) begin
        div_r[i] <= {div_r[i][DW-2:0], 1'b0};
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  // Busy also covers the cycle in which the core loads the fresh residues.
  assign busy     = busy_r | start | done_r;
  assign done     = done_r;
  assign pos_mod  = rem_r[0][POS_BITS-1:0];
  assign step_mod = rem_r[1][STEP_W-1:0];
  assign mag_mod  = rem_r[2][STEP_W-1:0];

endmodule

`default_nettype wire

// ----- src/smpg_core.sv -----
// ============================================================================
// Step pulse generator core
// Position, wait timer and pin state, updated once per request, with result register.
// ============================================================================
`default_nettype none

module smpg_core #(
  parameter int POS_BITS   = smpg_pkg::POS_BITS_DEF,
  parameter int TIMER_BITS = smpg_pkg::TIMER_BITS_DEF,
  localparam int OUT_W     = ((POS_BITS + 4 + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_acc,
  input  wire smpg_pkg::mode_t             mode,
  input  wire logic [POS_BITS-1:0]         goal,
  input  wire logic [smpg_pkg::STEP_W-1:0] step_size,
  input  wire logic [POS_BITS-1:0]         position_limit,
  input  wire logic [POS_BITS:0]           wrap_count,
  input  wire logic [TIMER_BITS-1:0]       half_period,
  input  wire logic [TIMER_BITS-1:0]       nudge_period,
  input  wire logic                        mod_done,
  input  wire logic [POS_BITS-1:0]         pos_mod,
  input  wire logic [smpg_pkg::STEP_W-1:0] step_mod,
  input  wire logic [smpg_pkg::STEP_W-1:0] mag_mod,
  output logic      [POS_BITS-1:0]         pos_out,
  output logic      [smpg_pkg::STEP_W-1:0] mag_out,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [OUT_W-1:0]            out_tdata
);
  import smpg_pkg::*;

  localparam int SW = POS_BITS + 2;

  // Sequencer state.
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [POS_BITS-1:0]   rmod_r, rmod_nxt;
  logic [STEP_W-1:0]     smod_r, smod_nxt;
  logic [POS_BITS-1:0]   goal_r, goal_nxt;
  logic                  neg_r, neg_nxt;
  logic [STEP_W-1:0]     mag_r, mag_nxt;
  logic [STEP_W-1:0]     dm_r, dm_nxt;
  logic                  moving_r, moving_nxt;
  logic                  nudging_r, nudging_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] tick_r, tick_nxt;
  logic                  level_r, level_nxt;
  logic [2:0]            pins_r, pins_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  // Step arithmetic.
  logic                  move_neg;
  logic                  sel_neg;
  logic [STEP_W-1:0]     sel_mag;
  logic [STEP_W-1:0]     sel_dm;
  logic [SW-1:0]         pos_ext, mag_ext, r_ext, dm_ext, w_ext;
  logic [SW-1:0]         sum, t_up, t_dn, t_res;
  logic                  under;
  logic                  next_ok;
  logic [POS_BITS-1:0]   wrapped;

  // Step line toggle: skipped at or beyond the limit. Returns {level, pins}.
  function automatic logic [3:0] toggle_fn(input logic [POS_BITS-1:0] pos,
                                           input logic [POS_BITS-1:0] lim,
                                           input logic lvl,
                                           input logic [2:0] pins,
                                           input logic neg);
    logic [3:0] res;
    res = {lvl, pins};
    if (pos < lim) begin
      res[3]                = ~lvl;
      res[PIN_STEP_BIT]     = ~lvl;
      res[PIN_DIR_BIT]      = neg;
      res[PIN_EN_BIT]       = pins[PIN_EN_BIT];
    end
    return res;
  endfunction

  // Direction and step size in effect for this request.
  assign move_neg = (pos_r > goal) && (step_size != '0);
  assign sel_neg  = (mode == MODE_MOVE) ? move_neg  : neg_r;
  assign sel_mag  = (mode == MODE_MOVE) ? step_size : mag_r;
  assign sel_dm   = (mode == MODE_MOVE) ? smod_r    : dm_r;

  // Next position, range check, and its remainder from the tracked residues.
  assign pos_ext = SW'(pos_r);
  assign mag_ext = SW'(sel_mag);
  assign r_ext   = SW'(rmod_r);
  assign dm_ext  = SW'(sel_dm);
  assign w_ext   = SW'(wrap_count);
  assign sum     = sel_neg ? (pos_ext - mag_ext) : (pos_ext + mag_ext);
  assign under   = sel_neg && (mag_ext > pos_ext);
  assign next_ok = !under && (sum < SW'(position_limit));
  assign t_up    = r_ext + dm_ext;
  assign t_dn    = (r_ext < dm_ext) ? (r_ext + w_ext - dm_ext) : (r_ext - dm_ext);

  always_comb begin
    if (sel_neg) begin
      t_res = t_dn;
    end else if (t_up >= w_ext) begin
      t_res = t_up - w_ext;
    end else begin
      t_res = t_up;
    end
  end

  assign wrapped = (wrap_count == '0) ? sum[POS_BITS-1:0] : t_res[POS_BITS-1:0];

  // Request handling.
  always_comb begin
    logic [3:0] tg;
    tg          = '0;
    pos_nxt     = pos_r;
    rmod_nxt    = rmod_r;
    smod_nxt    = smod_r;
    goal_nxt    = goal_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    dm_nxt      = dm_r;
    moving_nxt  = moving_r;
    nudging_nxt = nudging_r;
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    level_nxt   = level_r;
    pins_nxt    = pins_r;

    // Fresh residues after a step size or wrap count change.
    if (mod_done) begin
      rmod_nxt = pos_mod;
      smod_nxt = step_mod;
      dm_nxt   = mag_mod;
    end

    if (in_acc) begin
      unique case (mode)
        MODE_TICK: begin
          if (phase_r != PH_CHECK) begin
            if (tick_r > TIMER_BITS'(1)) begin
              tick_nxt = tick_r - 1'b1;
            end else begin
              unique case (phase_r)
                PH_HALF1: begin
                  tg        = toggle_fn(pos_r, position_limit, level_r, pins_r, neg_r);
                  level_nxt = tg[3];
                  pins_nxt  = tg[2:0];
                  tick_nxt  = half_period;
                  phase_nxt = PH_HALF2;
                end
                PH_HALF2: begin
                  if ((goal_r != pos_r) && moving_r && next_ok) begin
                    pos_nxt   = wrapped;
                    rmod_nxt  = wrapped;
                    tg        = toggle_fn(wrapped, position_limit, level_r, pins_r, neg_r);
                    level_nxt = tg[3];
                    pins_nxt  = tg[2:0];
                    tick_nxt  = half_period;
                    phase_nxt = PH_HALF1;
                  end else begin
                    moving_nxt  = 1'b0;
                    nudging_nxt = 1'b0;
                    phase_nxt   = PH_CHECK;
                    tick_nxt    = '0;
                    pins_nxt    = PINS_RELEASED;
                  end
                end
                PH_NUDGE: begin
                  pos_nxt     = wrapped;
                  rmod_nxt    = wrapped;
                  moving_nxt  = 1'b0;
                  nudging_nxt = 1'b0;
                  phase_nxt   = PH_CHECK;
                  tick_nxt    = '0;
                  pins_nxt    = PINS_RELEASED;
                end
                default: ;
              endcase
            end
          end
        end
        MODE_MOVE: begin
          goal_nxt    = goal;
          nudging_nxt = 1'b0;
          moving_nxt  = 1'b1;
          phase_nxt   = PH_CHECK;
          tick_nxt    = '0;
          pins_nxt    = pins_r;
          pins_nxt[PIN_EN_BIT] = 1'b0;
          neg_nxt     = move_neg;
          mag_nxt     = step_size;
          dm_nxt      = smod_r;
          if ((goal != pos_r) && next_ok) begin
            pos_nxt   = wrapped;
            rmod_nxt  = wrapped;
            tg        = toggle_fn(wrapped, position_limit, level_r, pins_nxt, move_neg);
            level_nxt = tg[3];
            pins_nxt  = tg[2:0];
            tick_nxt  = half_period;
            phase_nxt = PH_HALF1;
          end else begin
            moving_nxt  = 1'b0;
            nudging_nxt = 1'b0;
            phase_nxt   = PH_CHECK;
            tick_nxt    = '0;
            pins_nxt    = PINS_RELEASED;
          end
        end
        MODE_HALT: begin
          moving_nxt  = 1'b0;
          nudging_nxt = 1'b0;
          phase_nxt   = PH_CHECK;
          tick_nxt    = '0;
          pins_nxt    = PINS_RELEASED;
        end
        MODE_NUDGE: begin
          moving_nxt = 1'b0;
          phase_nxt  = PH_CHECK;
          tick_nxt   = '0;
          pins_nxt   = pins_r;
          pins_nxt[PIN_EN_BIT] = 1'b0;
          neg_nxt    = pos_r > goal_r;
          mag_nxt    = STEP_W'(1);
          dm_nxt     = (wrap_count == (POS_BITS + 1)'(1)) ? '0 : STEP_W'(1);
          // Stepping down needs a nonzero position, which pos > goal guarantees.
          if (pos_r < position_limit) begin
            tg          = toggle_fn(pos_r, position_limit, level_r, pins_nxt,
                                    pos_r > goal_r);
            level_nxt   = tg[3];
            pins_nxt    = tg[2:0];
            tick_nxt    = nudge_period;
            phase_nxt   = PH_NUDGE;
            nudging_nxt = 1'b1;
          end else begin
            moving_nxt  = 1'b0;
            nudging_nxt = 1'b0;
            phase_nxt   = PH_CHECK;
            tick_nxt    = '0;
            pins_nxt    = PINS_RELEASED;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rmod_r    <= '0;
      smod_r    <= STEP_W'(STEP_RESET);
      goal_r    <= '0;
      neg_r     <= 1'b0;
      mag_r     <= '0;
      dm_r      <= '0;
      moving_r  <= 1'b0;
      nudging_r <= 1'b0;
      phase_r   <= PH_CHECK;
      tick_r    <= '0;
      level_r   <= 1'b0;
      pins_r    <= PINS_RELEASED;
    end else begin
      pos_r     <= pos_nxt;
      rmod_r    <= rmod_nxt;
      smod_r    <= smod_nxt;
      goal_r    <= goal_nxt;
      neg_r     <= neg_nxt;
      mag_r     <= mag_nxt;
      dm_r      <= dm_nxt;
      moving_r  <= moving_nxt;
      nudging_r <= nudging_nxt;
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      level_r   <= level_nxt;
      pins_r    <= pins_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: step, dir, enable, position, busy from the lowest bit up.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_W'({moving_nxt | nudging_nxt, pos_nxt, pins_nxt[PIN_EN_BIT],
                            pins_nxt[PIN_DIR_BIT], pins_nxt[PIN_STEP_BIT]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pos_out    = pos_r;
  assign mag_out    = mag_r;

`ifndef SYNTHESIS
  // No wait count survives outside a wait phase.
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CHECK) |-> (tick_r == '0))
    else $error("wait count left in checking phase");

  // A move and a nudge never run together.
  a_one_activity: assert property (@(posedge clk) disable iff (!rst_n)
    !(moving_r && nudging_r))
    else $error("move and nudge both active");

  // An idle driver is always released.
  a_released: assert property (@(posedge clk) disable iff (!rst_n)
    (!moving_r && !nudging_r) |-> (pins_r == PINS_RELEASED))
    else $error("pins energized while idle");

  // The tracked residue never exceeds the position it stands for.
  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    rmod_r <= pos_r)
    else $error("position residue out of range");

  // Every accepted request leaves a result waiting.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("request accepted without result");
`endif

endmodule

`default_nettype wire

// ----- src/stepper_move_pulse_generator_top.sv -----
// ============================================================================
// Stepper move pulse generator
// Step/direction pulse generation from tick and command requests.
// ============================================================================
//  channel | direction | tdata                      | tuser
//  in_     | slave     | goal                       | mode
//  out_    | master    | step, dir, enable, pos, busy | none
//  cfg_    | write     | register data by index     | none
//
//  One request per clock while in_tready is high; each request yields one
//  result, registered and shown in the next cycle. After a write to
//  step_size or wrap_count the serial remainder unit runs, and in_tready is
//  held low from its start until the core has loaded the fresh residues.
//  Reset is synchronous, active low; no clearing pass is needed.
//  in_tready follows out_tready when the result register is full.
// ============================================================================
`default_nettype none

module stepper_move_pulse_generator_top #(
  parameter int POS_BITS   = smpg_pkg::POS_BITS_DEF,
  parameter int TIMER_BITS = smpg_pkg::TIMER_BITS_DEF,
  localparam int CFG_W     = smpg_pkg::max_int(TIMER_BITS, POS_BITS + 1),
  localparam int IN_W      = ((POS_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((POS_BITS + 4 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // goal
  input  wire logic [1:0]       in_tuser,   // mode
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata,  // step_pin, dir_pin, enable_pin,
                                            // current_position, busy_res
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata
);
  import smpg_pkg::*;

  logic [STEP_W-1:0]     step_size;
  logic [POS_BITS-1:0]   position_limit;
  logic [POS_BITS:0]     wrap_count;
  logic [TIMER_BITS-1:0] half_period;
  logic [TIMER_BITS-1:0] nudge_period;
  logic                  recalc;
  logic                  mod_busy;
  logic                  mod_done;
  logic [POS_BITS-1:0]   pos_mod;
  logic [STEP_W-1:0]     step_mod;
  logic [STEP_W-1:0]     mag_mod;
  logic [POS_BITS-1:0]   pos_cur;
  logic [STEP_W-1:0]     mag_cur;
  logic                  in_acc;

  // Accept while the remainder unit is idle and the result register can load.
  assign in_tready = !mod_busy && (!out_tvalid || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  smpg_cfg_regs #(
    .POS_BITS   (POS_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .step_size      (step_size),
    .position_limit (position_limit),
    .wrap_count     (wrap_count),
    .half_period    (half_period),
    .nudge_period   (nudge_period),
    .recalc         (recalc)
  );

  smpg_mod_unit #(
    .POS_BITS (POS_BITS)
  ) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (recalc),
    .wrap_count (wrap_count),
    .pos_in     (pos_cur),
    .step_in    (step_size),
    .mag_in     (mag_cur),
    .busy       (mod_busy),
    .done       (mod_done),
    .pos_mod    (pos_mod),
    .step_mod   (step_mod),
    .mag_mod    (mag_mod)
  );

  smpg_core #(
    .POS_BITS   (POS_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_acc         (in_acc),
    .mode           (mode_t'(in_tuser)),
    .goal           (in_tdata[POS_BITS-1:0]),
    .step_size      (step_size),
    .position_limit (position_limit),
    .wrap_count     (wrap_count),
    .half_period    (half_period),
    .nudge_period   (nudge_period),
    .mod_done       (mod_done),
    .pos_mod        (pos_mod),
    .step_mod       (step_mod),
    .mag_mod        (mag_mod),
    .pos_out        (pos_cur),
    .mag_out        (mag_cur),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

`default_nettype wire
